### src/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB converter.
// Used by hsv2rgb_pipe and hsv_to_rgb_converter; depends on nothing else.
`default_nettype none

package hsv2rgb_pkg;

    // Field widths
    localparam int HUE_W   = 9;    // hue in degrees
    localparam int CH_W    = 8;    // one colour channel, also s and v
    localparam int REM_W   = 6;    // degrees within a sector, 0..59
    localparam int KS_W    = 14;   // s * remainder, up to 255*60
    localparam int QN_W    = 22;   // v * (15300 - s*rem), up to 255*15300
    localparam int PN_W    = 16;   // v * (255 - s)

    // Hue geometry
    localparam int HUE_WRAP = 360;
    localparam int SEG_DEG  = 60;

    // Denominators of the scaled terms
    localparam logic [CH_W-1:0] FULL_SCALE = 8'd255;
    localparam logic [KS_W-1:0] Q_DEN      = 14'd15300;

    // Exact reciprocals: floor(x/15300) = (x*Q_RECIP) >> Q_SHIFT for x < 2^22,
    // floor(x/255) = (x*P_RECIP) >> P_SHIFT for x < 2^16.
    localparam int              Q_RECIP_W = 23;
    localparam logic [Q_RECIP_W-1:0] Q_RECIP = 23'd4491470;
    localparam int              Q_SHIFT   = 36;
    localparam int              QP_W      = QN_W + Q_RECIP_W;
    localparam int              P_RECIP_W = 17;
    localparam logic [P_RECIP_W-1:0] P_RECIP = 17'd65794;
    localparam int              P_SHIFT   = 24;
    localparam int              PP_W      = PN_W + P_RECIP_W;

    // Configuration register indexes
    localparam int REG_SAT = 0;
    localparam int REG_VAL = 1;

    // Hue sectors, named by the colour span they cover
    typedef enum logic [2:0] {
        SEC_RY = 3'd0,   // red to yellow
        SEC_YG = 3'd1,   // yellow to green
        SEC_GC = 3'd2,   // green to cyan
        SEC_CB = 3'd3,   // cyan to blue
        SEC_BM = 3'd4,   // blue to magenta
        SEC_MR = 3'd5    // magenta to red
    } t_sector;

    // Saturation and value as seen by the datapath
    typedef struct packed {
        logic [CH_W-1:0] sat;
        logic [CH_W-1:0] val;
    } t_cfg;

endpackage

`default_nettype wire

### src/hsv2rgb_pipe.sv
// Five-stage HSV to RGB arithmetic pipeline with per-stage valid and ready.
// Depends on hsv2rgb_pkg for widths, reciprocals and the sector type.
`default_nettype none

module hsv2rgb_pipe
    import hsv2rgb_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_cfg            i_cfg,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [HUE_W-1:0] i_hue,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [CH_W-1:0]      o_red,
    output logic [CH_W-1:0]      o_green,
    output logic [CH_W-1:0]      o_blue
);

    // Stage valids and the ready chain back from the output
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_rdy2, w_rdy3, w_rdy4, w_rdy5;

    assign w_rdy5  = !r_v5 || i_ready;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign o_ready = !r_v1 || w_rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (o_ready) r_v1 <= i_valid;
            if (w_rdy2)  r_v2 <= r_v1;
            if (w_rdy3)  r_v3 <= r_v2;
            if (w_rdy4)  r_v4 <= r_v3;
            if (w_rdy5)  r_v5 <= r_v4;
        end
    end

    // Stage 1: wrap the hue once and split it into sector and remainder
    logic [HUE_W-1:0] n_hue;
    logic [HUE_W-1:0] n_base;
    logic [HUE_W-1:0] n_diff;
    t_sector          n_sec;
    t_sector          r_sec1;
    logic [REM_W-1:0] r_rem1;

    always_comb begin
        n_hue = (i_hue >= HUE_W'(HUE_WRAP)) ? i_hue - HUE_W'(HUE_WRAP) : i_hue;
        priority if (n_hue >= HUE_W'(5 * SEG_DEG)) begin
            n_sec  = SEC_MR;
            n_base = HUE_W'(5 * SEG_DEG);
        end else if (n_hue >= HUE_W'(4 * SEG_DEG)) begin
            n_sec  = SEC_BM;
            n_base = HUE_W'(4 * SEG_DEG);
        end else if (n_hue >= HUE_W'(3 * SEG_DEG)) begin
            n_sec  = SEC_CB;
            n_base = HUE_W'(3 * SEG_DEG);
        end else if (n_hue >= HUE_W'(2 * SEG_DEG)) begin
            n_sec  = SEC_GC;
            n_base = HUE_W'(2 * SEG_DEG);
        end else if (n_hue >= HUE_W'(SEG_DEG)) begin
            n_sec  = SEC_YG;
            n_base = HUE_W'(SEG_DEG);
        end else begin
            n_sec  = SEC_RY;
            n_base = '0;
        end
        n_diff = n_hue - n_base;
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_sec1 <= n_sec;
            r_rem1 <= n_diff[REM_W-1:0];
        end
    end

    // Stage 2: saturation times remainder and its complement, and v*(255-s)
    t_sector          r_sec2;
    logic [KS_W-1:0]  r_ksq2;
    logic [KS_W-1:0]  r_kst2;
    logic [PN_W-1:0]  r_pn2;
    logic [REM_W-1:0] n_rem_c;

    assign n_rem_c = REM_W'(SEG_DEG) - r_rem1;

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_sec2 <= r_sec1;
            r_ksq2 <= KS_W'(i_cfg.sat) * KS_W'(r_rem1);
            r_kst2 <= KS_W'(i_cfg.sat) * KS_W'(n_rem_c);
            r_pn2  <= PN_W'(i_cfg.val) * PN_W'(FULL_SCALE - i_cfg.sat);
        end
    end

    // Stage 3: scale by v, and start the divide by 255 for p
    t_sector          r_sec3;
    logic [QN_W-1:0]  r_qn3;
    logic [QN_W-1:0]  r_tn3;
    logic [PP_W-1:0]  r_pm3;

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_sec3 <= r_sec2;
            r_qn3  <= QN_W'(i_cfg.val) * QN_W'(Q_DEN - r_ksq2);
            r_tn3  <= QN_W'(i_cfg.val) * QN_W'(Q_DEN - r_kst2);
            r_pm3  <= PP_W'(r_pn2) * PP_W'(P_RECIP);
        end
    end

    // Stage 4: divide by 15300 through the reciprocal, take p's quotient
    t_sector          r_sec4;
    logic [CH_W-1:0]  r_q4;
    logic [CH_W-1:0]  r_t4;
    logic [CH_W-1:0]  r_p4;
    logic [QP_W-1:0]  n_qprod;
    logic [QP_W-1:0]  n_tprod;

    assign n_qprod = QP_W'(r_qn3) * QP_W'(Q_RECIP);
    assign n_tprod = QP_W'(r_tn3) * QP_W'(Q_RECIP);

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_sec4 <= r_sec3;
            r_q4   <= n_qprod[Q_SHIFT+CH_W-1:Q_SHIFT];
            r_t4   <= n_tprod[Q_SHIFT+CH_W-1:Q_SHIFT];
            r_p4   <= r_pm3[P_SHIFT+CH_W-1:P_SHIFT];
        end
    end

    // Stage 5: route p, q, t and v by sector; zero saturation yields p=q=t=v
    logic [CH_W-1:0] n_red, n_green, n_blue;
    logic [CH_W-1:0] r_red, r_green, r_blue;

    always_comb begin
        unique case (r_sec4)
            SEC_RY: begin
                n_red = i_cfg.val; n_green = r_t4;      n_blue = r_p4;
            end
            SEC_YG: begin
                n_red = r_q4;      n_green = i_cfg.val; n_blue = r_p4;
            end
            SEC_GC: begin
                n_red = r_p4;      n_green = i_cfg.val; n_blue = r_t4;
            end
            SEC_CB: begin
                n_red = r_p4;      n_green = r_q4;      n_blue = i_cfg.val;
            end
            SEC_BM: begin
                n_red = r_t4;      n_green = r_p4;      n_blue = i_cfg.val;
            end
            default: begin
                n_red = i_cfg.val; n_green = r_p4;      n_blue = r_q4;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_valid = r_v5;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    // Remainder never reaches a full sector
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (r_rem1 < REM_W'(SEG_DEG)))
        else $error("sector remainder out of range");

    // A beat leaving stage 4 always lands in the output stage
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && w_rdy4) |=> r_v5)
        else $error("beat lost between stage 4 and output");

    // Sector travels alongside its data when stage 3 advances
    a_sec_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && w_rdy4) |=> (r_sec4 == $past(r_sec3)))
        else $error("sector out of step with data");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_v1 && !r_v5 && o_ready))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

### src/hsv_to_rgb_converter.sv
// HSV to RGB converter top level: APB register file and stream wrapper.
// Depends on hsv2rgb_pkg and instantiates hsv2rgb_pipe.
//
// Usage:
//   Hue beats (whole degrees, 0..360; 360 reads as 0, 361..511 fold once) enter
//   on the s_axis channel, one per clock while s_axis_tready is high. Each beat
//   yields exactly one RGB beat on the m_axis channel, in order.
//   Saturation (register 0, byte address 0, reset 255) and value (register 1,
//   byte address 4, reset 8) sit behind the APB port, 255 meaning 1.0. Write
//   them only while no beat is in flight.
//   Pipeline: five register stages, all passed before a beat shows on m_axis.
//   Throughput: one beat per cycle while m_axis does not stall, set by the
//   pipeline, whose widest step is a 22 x 23 bit reciprocal multiply.
//   Reset (synchronous, active low) empties the pipeline and restores both
//   registers. When the receiver stalls, each stage holds until the next one
//   frees; s_axis_tready falls only once all five stages hold a beat.
`default_nettype none

module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [8:0] hue, [15:9] zero
    // Output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Register file
    logic [CH_W-1:0] r_sat, r_val;
    logic            w_wr;
    logic            w_idx;
    t_cfg            w_cfg;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 8'd255;
            r_val <= 8'd8;
        end else if (w_wr) begin
            if (w_idx == 1'(REG_SAT)) r_sat <= pwdata[CH_W-1:0];
            if (w_idx == 1'(REG_VAL)) r_val <= pwdata[CH_W-1:0];
        end
    end

    // Read back the addressed register
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            1'(REG_SAT): prdata[CH_W-1:0] = r_sat;
            default:     prdata[CH_W-1:0] = r_val;
        endcase
    end

    assign w_cfg.sat = r_sat;
    assign w_cfg.val = r_val;

    // Arithmetic pipeline
    logic [CH_W-1:0] w_red, w_green, w_blue;

    hsv2rgb_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_hue   (s_axis_tdata[HUE_W-1:0]),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_red   (w_red),
        .o_green (w_green),
        .o_blue  (w_blue)
    );

    assign m_axis_tdata = {w_blue, w_green, w_red};

endmodule

`default_nettype wire

### tb/hsv2rgb_checker.sv
`timescale 1ns / 100ps
// Scoreboard for hsv_to_rgb_converter: snoops APB writes and both stream channels,
// predicts every RGB beat from the hue and the live settings, and compares field by field.
// Depends on hsv2rgb_pkg for widths, register indexes and the sector enum.

module hsv2rgb_checker
    import hsv2rgb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Hue channel
    input  wire logic        i_hue_valid,
    input  wire logic        i_hue_ready,
    input  wire logic [15:0] i_hue_data,    // [8:0] hue, [15:9] zero
    // RGB channel
    input  wire logic        i_rgb_valid,
    input  wire logic        i_rgb_ready,
    input  wire logic [23:0] i_rgb_data,    // [7:0] red, [15:8] green, [23:16] blue
    // Configuration port
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic        i_pready,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_rgb;

    t_cfg cfg_now;
    t_rgb rgb_due[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        cfg_now.sat  = FULL_SCALE;
        cfg_now.val  = 8'd8;
    end

    // Colour of one hue under the given saturation and value, truncated terms
    function automatic t_rgb rgb_from_hue(input logic [HUE_W-1:0] hue_in, input t_cfg cfg);
        int unsigned hue, rem, s, v, p, q, t;
        t_sector     sector;
        t_rgb        rgb;
        hue = hue_in;
        if (hue >= HUE_WRAP) begin
            hue = hue - HUE_WRAP;
        end
        s      = cfg.sat;
        v      = cfg.val;
        sector = t_sector'(hue / SEG_DEG);
        rem    = hue % SEG_DEG;
        p      = v * (int'(FULL_SCALE) - s) / int'(FULL_SCALE);
        q      = v * (int'(Q_DEN) - s * rem) / int'(Q_DEN);
        t      = v * (int'(Q_DEN) - s * (SEG_DEG - rem)) / int'(Q_DEN);
        if (s == 0) begin
            // grey: every channel sits at the value level
            rgb.red   = CH_W'(v);
            rgb.green = CH_W'(v);
            rgb.blue  = CH_W'(v);
        end else begin
            case (sector)
                SEC_RY: begin rgb.red = CH_W'(v); rgb.green = CH_W'(t); rgb.blue = CH_W'(p); end
                SEC_YG: begin rgb.red = CH_W'(q); rgb.green = CH_W'(v); rgb.blue = CH_W'(p); end
                SEC_GC: begin rgb.red = CH_W'(p); rgb.green = CH_W'(v); rgb.blue = CH_W'(t); end
                SEC_CB: begin rgb.red = CH_W'(p); rgb.green = CH_W'(q); rgb.blue = CH_W'(v); end
                SEC_BM: begin rgb.red = CH_W'(t); rgb.green = CH_W'(p); rgb.blue = CH_W'(v); end
                default: begin rgb.red = CH_W'(v); rgb.green = CH_W'(p); rgb.blue = CH_W'(q); end
            endcase
        end
        return rgb;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch on RGB beat %0d: got %0d, want %0d",
                 $time, what, o_checked, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_rgb got;
        t_rgb want;
        if (!i_rst_n) begin
            // restore register defaults and drop anything in flight
            cfg_now.sat = FULL_SCALE;
            cfg_now.val = 8'd8;
            rgb_due.delete();
        end else begin
            // track register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if ((i_paddr >> 2) == REG_SAT) begin
                    cfg_now.sat = i_pwdata[CH_W-1:0];
                end else if ((i_paddr >> 2) == REG_VAL) begin
                    cfg_now.val = i_pwdata[CH_W-1:0];
                end
            end
            // check the RGB beat against the oldest prediction
            if (i_rgb_valid && i_rgb_ready) begin
                got = i_rgb_data;
                if (rgb_due.size() == 0) begin
                    $display("%0t: RGB beat with no hue outstanding: %06h", $time, i_rgb_data);
                    o_fail_count++;
                end else begin
                    want = rgb_due.pop_front();
                    if (got.red !== want.red) report_mismatch("red", got.red, want.red);
                    if (got.green !== want.green) report_mismatch("green", got.green, want.green);
                    if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
                end
                o_checked++;
            end
            // predict the colour of each accepted hue
            if (i_hue_valid && i_hue_ready) begin
                rgb_due.push_back(rgb_from_hue(i_hue_data[HUE_W-1:0], cfg_now));
            end
        end
        o_pending = rgb_due.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the hsv_to_rgb_converter testbench: clock, reset, hue stimulus, APB settings,
// output back-pressure and the verdict. Depends on hsv2rgb_pkg and hsv2rgb_checker.

module tb_top
    import hsv2rgb_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 200;
    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 105;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [15:0] s_axis_tdata = '0;   // [8:0] hue, [15:9] zero
    logic        m_axis_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [23:0] m_axis_tdata;        // [7:0] red, [15:8] green, [23:16] blue
    wire  [31:0] prdata;
    wire         pready;

    int fail_count;
    int pending;
    int checked;
    int hues_sent = 0;
    int settings_used = 0;
    int quiet_cycles = 0;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_req = 1'b0;

    hsv_to_rgb_converter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    hsv2rgb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hue_valid  (s_axis_tvalid),
        .i_hue_ready  (s_axis_tready),
        .i_hue_data   (s_axis_tdata),
        .i_rgb_valid  (m_axis_tvalid),
        .i_rgb_ready  (m_axis_tready),
        .i_rgb_data   (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Abort when no beat and no register access has moved for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Output back-pressure: random stall bursts, plus one long hold-off on request
    initial begin
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Offer one hue and hold it until accepted; maybe idle afterwards
    task automatic send_hue(input logic [HUE_W-1:0] hue);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, hue};
        do @(posedge i_clk); while (!s_axis_tready);
        hues_sent++;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // Stop offering, wait for every outstanding colour, then let the pipeline settle
    task automatic wait_idle();
        if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // APB write: setup cycle, access cycle, then release the bus
    task automatic write_reg(input int idx, input logic [CH_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(idx * 4);
        pwdata  <= {24'd0, data};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [CH_W-1:0] sat, input logic [CH_W-1:0] val);
        wait_idle();
        write_reg(REG_SAT, sat);
        write_reg(REG_VAL, val);
        settings_used++;
    endtask

    // Mostly legal hues, a quarter from the folded range above 360
    function automatic logic [HUE_W-1:0] random_hue();
        if ($urandom_range(0, 3) == 0) return HUE_W'($urandom_range(HUE_WRAP + 1, 511));
        return HUE_W'($urandom_range(0, HUE_WRAP));
    endfunction

    initial begin
        int corner_hues[20];
        logic [CH_W-1:0] sat;
        logic [CH_W-1:0] val;
        corner_hues = '{0, 1, 59, 60, 61, 119, 120, 179, 180, 239,
                        240, 299, 300, 359, 360, 361, 511, 255, 256, 170};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sector edges, wrap and fold at reset settings
        settings_used = 1;
        foreach (corner_hues[k]) send_hue(HUE_W'(corner_hues[k]));
        // Grey at full value
        apply_setting(8'd0, 8'd255);
        send_hue(9'd0);
        send_hue(9'd200);
        send_hue(9'd511);

        // Random hues under a sweep of settings; the last phase runs without idling
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin sat = 8'd255; val = 8'd255; end
                1: begin sat = 8'd0;   val = 8'd200; end
                2: begin sat = 8'd1;   val = 8'd255; end
                3: begin sat = 8'd255; val = 8'd0;   end
                5: begin sat = 8'd200; val = 8'd1;   end
                default: begin
                    sat = CH_W'($urandom_range(0, 255));
                    val = CH_W'($urandom_range(0, 255));
                end
            endcase
            apply_setting(sat, val);
            if (ph == PHASES - 1) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == 30) hold_req = 1'b1;
                send_hue(random_hue());
            end
        end

        wait_idle();
        $display("covered %0d hues over %0d saturation/value settings, %0d colours checked,",
                 hues_sent, settings_used, checked);
        $display("including grey, folded hues, a long output hold-off and full-rate streaming");
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
